[hdl/dpb_pkg.sv]
// Shared types, field widths, codes and constants for the differential drive balancer.
// No dependencies; every other file of the block imports this package.
package dpb_pkg;

  // Fixed field widths.
  localparam int SPEED_W    = 12;
  localparam int GAIN_W     = 10;
  localparam int MODE_W     = 2;
  localparam int TARGET_W   = 16;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SPEED_CLAMP_DEF = 400;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(40);
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(40);
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(1192);

  // Divide by the gain scale with a reciprocal multiply. The magnitude of the
  // gain sum is limited to MAG_W bits first; anything larger saturates the
  // speeds anyway. With a 27-bit shift the rounded-up reciprocal is exact for
  // every magnitude below 2**20.
  localparam longint GAIN_DIV    = 100;
  localparam int     MAG_W       = 20;
  localparam int     RECIP_SHIFT = 27;
  localparam int     RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP_100 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + GAIN_DIV - 64'd1) / GAIN_DIV);
  localparam int QUO_W  = 14;
  localparam int ADJ_W  = QUO_W + 1;
  localparam int WIDE_W = ADJ_W + 1;

  // Request kinds on the input channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_START = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_LEFT  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Turn modes; the unused code behaves as straight.
  localparam logic [MODE_W-1:0] MODE_STRAIGHT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPIN_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPIN_LEFT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd3;

  // What the speed stage does with a request.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_START,
    OP_TICK
  } op_t;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // Control carried along the pipeline with each request.
  typedef struct packed {
    op_t    op;
    logic   done;
    speed_t start_right;
    speed_t start_left;
  } pipe_ctl_t;

endpackage

[hdl/dpb_adj_scale.sv]
// Middle pipeline stage: magnitude, saturation and divide-by-gain-scale of the PD sum.
// Depends on dpb_pkg for the reciprocal constant, widths and the pipeline control struct.
module dpb_adj_scale import dpb_pkg::*; #(
  parameter int SUM_W = 29
) (
  input  logic                    clk,
  input  logic                    en,
  input  pipe_ctl_t               in_ctl,
  input  logic signed [SUM_W-1:0] in_sum,
  output pipe_ctl_t               out_ctl,
  output logic                    out_neg,
  output logic [QUO_W-1:0]        out_quo
);

  logic [SUM_W-1:0]         mag;
  logic [MAG_W-1:0]         mag_sat;
  logic [MAG_W+RECIP_W-1:0] prod;

  // Work on the magnitude so the quotient truncates toward zero.
  assign mag     = in_sum[SUM_W-1] ? $unsigned(-in_sum) : $unsigned(in_sum);
  assign mag_sat = (|mag[SUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
  assign prod    = mag_sat * RECIP_100;

  // Stage register; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl <= in_ctl;
      out_neg <= in_sum[SUM_W-1];
      out_quo <= prod[RECIP_SHIFT +: QUO_W];
    end
  end

endmodule

[hdl/differential_drive_pd_balancer.sv]
// Top level of the two-wheel PD speed balancer: request decode, wheel counters and the
// PD sum, then the speed update. Depends on dpb_pkg and dpb_adj_scale.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the request kind (start, right
//   pulse, left pulse, control tick) and s_tdata the two start speeds, used by start
//   only. Every request produces exactly one result on the m_ channel: the current
//   right and left speed commands in m_tdata and the move-done flag in m_tuser.
//   Gains, turn mode and target count are written through cfg_we / cfg_index /
//   cfg_data while no request is in flight.
// Timing:
//   Three register stages: counters and PD products, scaling by the gain divisor,
//   speed update into the output register. A request passes through them in that
//   order. One request is taken every cycle while m_tready stays high; the speed
//   registers are written only in the last stage, so the feedback needs no forwarding.
// Reset (rst, synchronous): counts, history and speeds go to zero, the registers to
//   their defaults, and the pipeline empties.
// Stall: when m_tready is low the result holds; the two earlier stages still fill,
//   and s_tready drops only once all three stages hold a request.
module differential_drive_pd_balancer import dpb_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int SPEED_CLAMP = SPEED_CLAMP_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,  // [11:0] start_speed_right, [23:12] start_speed_left
  input  logic [REQ_W-1:0]      s_tuser,  // [1:0] req_type
  // Results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,  // [11:0] speed_right, [23:12] speed_left
  output logic                  m_tuser,  // [0] move_done
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ERR_W  = COUNT_WIDTH + 1;
  localparam int RATE_W = COUNT_WIDTH + 2;
  localparam int SUM_W  = COUNT_WIDTH + 13;
  localparam int CMP_W  = (COUNT_WIDTH > TARGET_W) ? COUNT_WIDTH : TARGET_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic signed [WIDE_W-1:0] CLAMP_HI = WIDE_W'(SPEED_CLAMP);
  localparam logic signed [WIDE_W-1:0] SPD_MAX  = WIDE_W'((1 << (SPEED_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] SPD_MIN  = WIDE_W'(-(1 << (SPEED_W - 1)));

  // Configuration registers
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_d;
  logic [MODE_W-1:0]   turn_mode;
  logic [TARGET_W-1:0] target_ticks;

  // Wheel and history state
  logic [COUNT_WIDTH-1:0] count_right, count_right_next;
  logic [COUNT_WIDTH-1:0] count_left, count_left_next;
  logic [COUNT_WIDTH-1:0] prev_count_right, prev_count_right_next;
  logic [COUNT_WIDTH-1:0] prev_count_left, prev_count_left_next;
  logic signed [ERR_W-1:0] prev_error, prev_error_next;

  // Pipeline
  logic                    s_accept;
  logic                    a_valid, a_ready;
  pipe_ctl_t               a_ctl, a_ctl_next;
  logic signed [SUM_W-1:0] a_sum, sum_next;
  logic                    b_valid, b_ready;
  pipe_ctl_t               b_ctl;
  logic                    b_neg;
  logic [QUO_W-1:0]        b_quo;
  logic                    c_free;
  speed_t                  speed_right, speed_left;
  logic                    done_out;

  // Stage A datapath
  req_t                         req;
  logic                         done_now;
  logic [COUNT_WIDTH-1:0]       delta_right, delta_left;
  logic signed [ERR_W-1:0]      err;
  logic signed [RATE_W-1:0]     rate;
  logic signed [COUNT_WIDTH+11:0] prod_p;
  logic signed [COUNT_WIDTH+12:0] prod_d;

  // Stage C datapath
  logic signed [ADJ_W-1:0]  quo_s, adj;
  logic signed [WIDE_W-1:0] adj_w, right_w, left_w, right_new, left_new;

  function automatic speed_t sat_speed(input logic signed [WIDE_W-1:0] v);
    speed_t r;
    if (v > SPD_MAX) begin
      r = SPD_MAX[SPEED_W-1:0];
    end else if (v < SPD_MIN) begin
      r = SPD_MIN[SPEED_W-1:0];
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

  // Handshake: each stage takes a new request when it is empty or moving on.
  assign c_free   = !m_tvalid || m_tready;
  assign b_ready  = !b_valid || c_free;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;
  assign s_accept = s_tvalid && a_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RST;
      gain_d       <= GAIN_D_RST;
      turn_mode    <= MODE_STRAIGHT;
      target_ticks <= TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P: gain_p       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D: gain_d       <= cfg_data[GAIN_W-1:0];
        CFG_MODE:   turn_mode    <= cfg_data[MODE_W-1:0];
        CFG_TARGET: target_ticks <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // PD terms from the tick deltas; counts only grow between ticks, so deltas are never negative.
  assign req         = req_t'(s_tuser);
  assign done_now    = (CMP_W'(count_right) >= CMP_W'(target_ticks)) ||
                       (CMP_W'(count_left) >= CMP_W'(target_ticks));
  assign delta_right = count_right - prev_count_right;
  assign delta_left  = count_left - prev_count_left;
  assign err         = $signed({1'b0, delta_left}) - $signed({1'b0, delta_right});
  assign rate        = RATE_W'(err) - RATE_W'(prev_error);
  assign prod_p      = $signed({1'b0, gain_p}) * err;
  assign prod_d      = $signed({1'b0, gain_d}) * rate;
  assign sum_next    = SUM_W'(prod_p) + SUM_W'(prod_d);

  // Request decode and next state of the counters and history.
  always_comb begin
    count_right_next      = count_right;
    count_left_next       = count_left;
    prev_count_right_next = prev_count_right;
    prev_count_left_next  = prev_count_left;
    prev_error_next       = prev_error;
    a_ctl_next.op          = OP_HOLD;
    a_ctl_next.start_right = s_tdata[SPEED_W-1:0];
    a_ctl_next.start_left  = s_tdata[2*SPEED_W-1:SPEED_W];
    case (req)
      REQ_START: begin
        count_right_next      = '0;
        count_left_next       = '0;
        prev_count_right_next = '0;
        prev_count_left_next  = '0;
        prev_error_next       = '0;
        a_ctl_next.op         = OP_START;
      end
      REQ_RIGHT: begin
        count_right_next = (count_right == COUNT_MAX) ? count_right
                                                      : count_right + COUNT_WIDTH'(1);
      end
      REQ_LEFT: begin
        count_left_next = (count_left == COUNT_MAX) ? count_left
                                                    : count_left + COUNT_WIDTH'(1);
      end
      REQ_TICK: begin
        // Once the target is reached, ticks change nothing.
        if (!done_now) begin
          prev_count_right_next = count_right;
          prev_count_left_next  = count_left;
          prev_error_next       = err;
          a_ctl_next.op         = OP_TICK;
        end
      end
      default: ;
    endcase
    a_ctl_next.done = (CMP_W'(count_right_next) >= CMP_W'(target_ticks)) ||
                      (CMP_W'(count_left_next) >= CMP_W'(target_ticks));
  end

  // Stage A state and pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_right      <= '0;
      count_left       <= '0;
      prev_count_right <= '0;
      prev_count_left  <= '0;
      prev_error       <= '0;
      a_valid          <= 1'b0;
    end else begin
      if (s_accept) begin
        count_right      <= count_right_next;
        count_left       <= count_left_next;
        prev_count_right <= prev_count_right_next;
        prev_count_left  <= prev_count_left_next;
        prev_error       <= prev_error_next;
      end
      if (a_ready) begin
        a_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_ctl <= a_ctl_next;
      a_sum <= sum_next;
    end
  end

  // Stage B: divide by the gain scale.
  dpb_adj_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk     (clk),
    .en      (b_ready),
    .in_ctl  (a_ctl),
    .in_sum  (a_sum),
    .out_ctl (b_ctl),
    .out_neg (b_neg),
    .out_quo (b_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  // Stage C: apply the correction according to the turn mode.
  assign quo_s   = $signed({1'b0, b_quo});
  assign adj     = b_neg ? -quo_s : quo_s;
  assign adj_w   = WIDE_W'(adj);
  assign right_w = WIDE_W'(speed_right);
  assign left_w  = WIDE_W'(speed_left);

  always_comb begin
    case (turn_mode)
      MODE_SPIN_RIGHT: begin
        right_new = right_w - adj_w;
        left_new  = left_w - adj_w;
      end
      MODE_SPIN_LEFT: begin
        right_new = right_w + adj_w;
        left_new  = left_w + adj_w;
      end
      default: begin
        // Straight: opposite corrections, each limited from above.
        right_new = right_w + adj_w;
        left_new  = left_w - adj_w;
        if (right_new > CLAMP_HI) begin
          right_new = CLAMP_HI;
        end
        if (left_new > CLAMP_HI) begin
          left_new = CLAMP_HI;
        end
      end
    endcase
  end

  // Speed state doubles as the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_right <= '0;
      speed_left  <= '0;
      m_tvalid    <= 1'b0;
    end else if (c_free) begin
      m_tvalid <= b_valid;
      if (b_valid) begin
        case (b_ctl.op)
          OP_START: begin
            speed_right <= b_ctl.start_right;
            speed_left  <= b_ctl.start_left;
          end
          OP_TICK: begin
            speed_right <= sat_speed(right_new);
            speed_left  <= sat_speed(left_new);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_valid) begin
      done_out <= b_ctl.done;
    end
  end

  assign m_tdata = {speed_left, speed_right};
  assign m_tuser = done_out;

endmodule

[hdl/dpb_checker.sv]
// Port-level checks for the differential drive balancer, bound to the top level.
// Depends on dpb_pkg for the request codes and on the top level's port names.
module dpb_checker import dpb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [23:0]           s_tdata,
  input logic [REQ_W-1:0]      s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [23:0]           m_tdata,
  input logic                  m_tuser,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Requests are refused only when a result is waiting downstream.
  a_ready_backs_up: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input refused with output empty");

  // A start request into an empty pipeline goes through stages A and B into the output
  // register, where it shows valid with its start speeds as the result data.
  a_start_latency: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser == REQ_START) && !m_tvalid && !$past(s_acc) && !$past(s_acc, 2)
    |-> ##3 (m_tvalid && (m_tdata == $past(s_tdata, 3))))
    else $error("start request result missing or wrong");

endmodule

bind differential_drive_pd_balancer dpb_checker u_dpb_checker (.*);

[verif/differential_drive_pd_balancer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the differential drive PD speed balancer.
// Depends on dpb_pkg and the differential_drive_pd_balancer top level; needs nothing else.
module differential_drive_pd_balancer_tb;
  import dpb_pkg::*;

  localparam int SPEED_LIMIT    = 400;
  localparam int GAIN_SCALE     = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LINES   = 20;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // One request as the sender sees it: kind and the two start speeds.
  typedef struct packed {
    req_t                kind;
    logic [SPEED_W-1:0]  right;
    logic [SPEED_W-1:0]  left;
  } wheel_req_t;

  // One result: both speed commands and the done flag.
  typedef struct packed {
    logic [SPEED_W-1:0]  right;
    logic [SPEED_W-1:0]  left;
    logic                done;
  } drive_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = REQ_START;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAIN_P;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  differential_drive_pd_balancer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Balancer state as predicted by the testbench.
  logic [GAIN_W-1:0]   kp = GAIN_P_RST;
  logic [GAIN_W-1:0]   kd = GAIN_D_RST;
  logic [MODE_W-1:0]   drive_mode = MODE_STRAIGHT;
  logic [TARGET_W-1:0] goal_ticks = TARGET_RST;
  logic [15:0]         ticks_r = '0;
  logic [15:0]         ticks_l = '0;
  logic [15:0]         seen_r = '0;
  logic [15:0]         seen_l = '0;
  int                  last_err = 0;
  int                  cmd_r = 0;
  int                  cmd_l = 0;

  wheel_req_t pending_reqs[$];
  drive_cmd_t expected_cmds[$];
  wheel_req_t cur_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_done = 0;
  int n_settings = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  function automatic int clip_speed(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic logic goal_reached();
    return (ticks_r >= goal_ticks) || (ticks_l >= goal_ticks);
  endfunction

  // Advance the predicted state by one request and return the result it causes.
  function automatic drive_cmd_t balance_step(wheel_req_t rq);
    int d_r;
    int d_l;
    int err;
    int adj;
    int r;
    int l;
    drive_cmd_t cmd;
    case (rq.kind)
      REQ_START: begin
        ticks_r = '0;
        ticks_l = '0;
        seen_r = '0;
        seen_l = '0;
        last_err = 0;
        cmd_r = int'(signed'(rq.right));
        cmd_l = int'(signed'(rq.left));
      end
      REQ_RIGHT: if (ticks_r != 16'hFFFF) ticks_r = ticks_r + 16'd1;
      REQ_LEFT:  if (ticks_l != 16'hFFFF) ticks_l = ticks_l + 16'd1;
      default: begin
        // A tick after the goal changes nothing, not even the history.
        if (!goal_reached()) begin
          d_r = int'(ticks_r) - int'(seen_r);
          d_l = int'(ticks_l) - int'(seen_l);
          err = d_l - d_r;
          adj = (int'(kp) * err + int'(kd) * (err - last_err)) / GAIN_SCALE;
          last_err = err;
          seen_r = ticks_r;
          seen_l = ticks_l;
          r = cmd_r;
          l = cmd_l;
          if (drive_mode == MODE_SPIN_RIGHT) begin
            r = r - adj;
            l = l - adj;
          end else if (drive_mode == MODE_SPIN_LEFT) begin
            r = r + adj;
            l = l + adj;
          end else begin
            r = r + adj;
            l = l - adj;
            if (r > SPEED_LIMIT) r = SPEED_LIMIT;
            if (l > SPEED_LIMIT) l = SPEED_LIMIT;
          end
          cmd_r = clip_speed(r);
          cmd_l = clip_speed(l);
        end
      end
    endcase
    cmd.right = cmd_r[SPEED_W-1:0];
    cmd.left  = cmd_l[SPEED_W-1:0];
    cmd.done  = goal_reached();
    return cmd;
  endfunction

  task automatic report_mismatch(string what);
    if (n_errors < REPORT_LINES) $display("%0t ns: mismatch: %s", $time, what);
    n_errors++;
  endtask

  // Request driver: presents the queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_cmds.push_back(balance_step(cur_req));
        n_requests++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_req.kind;
        s_tdata <= {cur_req.left, cur_req.right};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (m_tuser) n_done++;
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result with no request pending (tdata %h)", m_tdata));
        end else begin
          want = expected_cmds.pop_front();
          if (m_tdata[11:0] !== want.right)
            report_mismatch($sformatf("speed_right %0d, predicted %0d",
                                      $signed(m_tdata[11:0]), $signed(want.right)));
          if (m_tdata[23:12] !== want.left)
            report_mismatch($sformatf("speed_left %0d, predicted %0d",
                                      $signed(m_tdata[23:12]), $signed(want.left)));
          if (m_tuser !== want.done)
            report_mismatch($sformatf("move_done %b, predicted %b", m_tuser, want.done));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake and no register write.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(req_t kind, int right = 0, int left = 0);
    wheel_req_t rq;
    rq.kind  = kind;
    rq.right = right[SPEED_W-1:0];
    rq.left  = left[SPEED_W-1:0];
    pending_reqs.push_back(rq);
  endtask

  task automatic push_run(req_t kind, int n);
    repeat (n) push_req(kind);
  endtask

  // Hold off until every queued request has gone and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_cmds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_GAIN_P: kp = value[GAIN_W-1:0];
      CFG_GAIN_D: kd = value[GAIN_W-1:0];
      CFG_MODE:   drive_mode = value[MODE_W-1:0];
      default:    goal_ticks = value[TARGET_W-1:0];
    endcase
  endtask

  // Write all four registers; only called with nothing in flight.
  task automatic apply_settings(int p, int d, logic [MODE_W-1:0] mode, int goal);
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_MODE, int'(mode));
    write_reg(CFG_TARGET, goal);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic int pick_gain();
    case ($urandom_range(5))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  // One plausible move: a start, then pulses from an uneven pair of wheels
  // with control ticks in between and a little noise.
  task automatic push_move();
    int span;
    int right_pct;
    int sr;
    int sl;
    sr = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 2047 : -2048) : $urandom_range(4095);
    sl = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 2047 : -2048) : $urandom_range(4095);
    push_req(REQ_START, sr, sl);
    span = $urandom_range(4, 40);
    right_pct = $urandom_range(15, 85);
    repeat (span) begin
      if ($urandom_range(9) == 0)
        push_req(req_t'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095));
      else if ($urandom_range(99) < 20)
        push_req(REQ_TICK, $urandom_range(4095), $urandom_range(4095));
      else if ($urandom_range(99) < right_pct)
        push_req(REQ_RIGHT);
      else
        push_req(REQ_LEFT);
    end
  endtask

  // Stimulus sequence.
  initial begin
    int base;
    int goal;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme start speeds, straight clamp, all request kinds.
    push_req(REQ_START, 2047, -2048);
    push_req(REQ_TICK);
    push_req(REQ_START, -2048, 2047);
    push_run(REQ_LEFT, 3);
    push_req(REQ_RIGHT);
    push_req(REQ_TICK);
    push_run(REQ_RIGHT, 4);
    push_req(REQ_TICK);
    push_req(REQ_TICK);
    push_req(REQ_START);
    wait_drained();

    // Zero target: done right after start, ticks ignored.
    apply_settings(1023, 1023, MODE_SPIN_RIGHT, 0);
    push_req(REQ_START, 5, -5);
    push_req(REQ_TICK);
    push_req(REQ_LEFT);
    wait_drained();

    // Left spin with a small target, reached in the middle of the sequence.
    apply_settings(1023, 1023, MODE_SPIN_LEFT, 4);
    push_req(REQ_START, -300, 300);
    push_run(REQ_LEFT, 2);
    push_req(REQ_TICK);
    push_req(REQ_RIGHT);
    push_req(REQ_TICK);
    push_run(REQ_LEFT, 3);
    push_req(REQ_TICK);
    wait_drained();

    // Random moves under each idling pattern, every turn mode among them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      goal = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(5, 40);
      apply_settings(pick_gain(), pick_gain(), MODE_W'(phase), goal);
      base = pending_reqs.size();
      while (pending_reqs.size() - base < 70) push_move();
      wait_drained();
      apply_settings(pick_gain(), pick_gain(), MODE_W'(3 - phase), $urandom_range(3, 30));
      base = pending_reqs.size();
      while (pending_reqs.size() - base < 70) push_move();
      wait_drained();
    end

    // Large errors of both signs in the spare mode, driving the speeds into the straight clamp.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_settings(1023, 1023, MODE_SPARE, 65535);
    push_req(REQ_START, 100, 100);
    push_run(REQ_LEFT, 30);
    push_req(REQ_TICK);
    push_req(REQ_START, -7, 7);
    push_run(REQ_RIGHT, 30);
    push_req(REQ_TICK);
    push_req(REQ_TICK);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("Checked %0d results of %0d requests (%0d with move done) over %0d settings,",
             n_results, n_requests, n_done, n_settings);
    $display("covering all turn modes, zero and maximal targets and saturated speed commands.");
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_cmds.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
